[design/cmnm_pkg.sv]
package cmnm_pkg;

  localparam int MAP_BYTES_DEF = 65536;

  localparam int IDX_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int NOVEL_W = 17;
  localparam int DROP_W  = 16;
  localparam int EPOCH_W = 8;

  localparam logic [NOVEL_W-1:0] NOVEL_MAX = {NOVEL_W{1'b1}};
  localparam logic [DROP_W-1:0]  DROP_MAX  = {DROP_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam int FIFO_DEPTH = 3;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [BYTE_W-1:0]  data;
  } entry_t;

  typedef struct packed {
    logic               keep_case;
    logic [NOVEL_W-1:0] novel_bytes;
    logic [DROP_W-1:0]  dropped_cases;
  } result_t;

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } ctl_state_t;

endpackage

[design/cmnm_ifs.sv]
interface cmnm_in_if;
  logic                         valid;
  logic                         ready;
  logic [cmnm_pkg::IDX_W-1:0]   map_index;
  logic [cmnm_pkg::BYTE_W-1:0]  coverage_byte;
  logic                         last_byte;
  logic                         new_pass;

  modport source (
    output valid, map_index, coverage_byte, last_byte, new_pass,
    input  ready
  );
  modport sink (
    input  valid, map_index, coverage_byte, last_byte, new_pass,
    output ready
  );
endinterface

interface cmnm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          keep_case;
  logic [cmnm_pkg::NOVEL_W-1:0]  novel_bytes;
  logic [cmnm_pkg::DROP_W-1:0]   dropped_cases;

  modport source (
    output valid, keep_case, novel_bytes, dropped_cases,
    input  ready
  );
  modport sink (
    input  valid, keep_case, novel_bytes, dropped_cases,
    output ready
  );
endinterface

[design/cmnm_map_ram.sv]
module cmnm_map_ram #(
  parameter int MAP_BYTES = cmnm_pkg::MAP_BYTES_DEF,
  parameter int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  cmnm_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output cmnm_pkg::entry_t rdata
);
  import cmnm_pkg::*;

  entry_t mem [MAP_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/cmnm_result_fifo.sv]
module cmnm_result_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  cmnm_pkg::result_t            push_data,
  output logic [cmnm_pkg::CNT_W-1:0]   count,
  cmnm_out_if.source                   out_ch
);
  import cmnm_pkg::*;

  result_t          slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;
  result_t          head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = slots[rd_ptr];

  assign out_ch.valid         = (count != '0);
  assign out_ch.keep_case     = head.keep_case;
  assign out_ch.novel_bytes   = head.novel_bytes;
  assign out_ch.dropped_cases = head.dropped_cases;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

[design/cmnm_merge.sv]
module cmnm_merge #(
  parameter int MAP_BYTES = cmnm_pkg::MAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  cmnm_in_if.sink                      in_ch,
  input  logic [cmnm_pkg::CNT_W-1:0]   fifo_count,
  output logic                         push,
  output cmnm_pkg::result_t            push_data
);
  import cmnm_pkg::*;

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam logic [AW-1:0] SWEEP_LAST = AW'(MAP_BYTES - 1);

  ctl_state_t         state;
  ctl_state_t         state_next;
  logic [AW-1:0]      sweep_addr;
  logic [EPOCH_W-1:0] epoch;

  logic               ready;
  logic               accept;
  logic               wrap_stall;
  logic               room;
  logic               in_range;

  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  entry_t             rd_entry;

  logic               s1_valid;
  logic [AW-1:0]      s1_idx;
  logic               s1_in_range;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_last;
  logic               s1_new_pass;
  logic [EPOCH_W-1:0] s1_epoch;

  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  entry_t             fwd_entry;

  entry_t             stored;
  logic [BYTE_W-1:0]  old_byte;
  logic [BYTE_W-1:0]  merged;
  logic               changed;
  logic               s1_wr;
  entry_t             s1_wdata;

  logic [NOVEL_W-1:0] novel_cnt;
  logic [DROP_W-1:0]  drop_cnt;
  logic [NOVEL_W-1:0] novel_base;
  logic [NOVEL_W-1:0] novel_new;
  logic [DROP_W-1:0]  drop_base;
  logic [DROP_W-1:0]  drop_new;
  logic               keep;

  assign accept     = in_ch.valid && ready;
  assign wrap_stall = in_ch.new_pass && (epoch == EPOCH_MAX);
  assign room       = ({1'b0, fifo_count} + (CNT_W + 1)'(s1_valid && s1_last))
                      <= (CNT_W + 1)'(FIFO_DEPTH - 1);
  assign in_range   = (32'(in_ch.map_index) < 32'(MAP_BYTES));
  assign in_ch.ready = ready;

  cmnm_map_ram #(
    .MAP_BYTES (MAP_BYTES),
    .AW        (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept && in_range),
    .raddr (AW'(in_ch.map_index)),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ready      = 1'b0;
    we         = 1'b0;
    waddr      = s1_idx;
    wdata      = s1_wdata;
    unique case (state)
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_addr;
        wdata = '0;
        if (sweep_addr == SWEEP_LAST) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ready = !wrap_stall && room;
        we    = s1_wr;
        if (in_ch.valid && wrap_stall && !s1_valid) begin
          state_next = ST_SWEEP;
        end
      end
      default: state_next = ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      epoch      <= '0;
    end else begin
      if (state == ST_SWEEP) begin
        sweep_addr <= (sweep_addr == SWEEP_LAST) ? '0 : sweep_addr + 1'b1;
      end
      if (state == ST_SWEEP && sweep_addr == SWEEP_LAST) begin
        epoch <= '0;
      end else if (accept && in_ch.new_pass) begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx      <= AW'(in_ch.map_index);
      s1_in_range <= in_range;
      s1_byte     <= in_ch.coverage_byte;
      s1_last     <= in_ch.last_byte;
      s1_new_pass <= in_ch.new_pass;
      s1_epoch    <= in_ch.new_pass ? epoch + 1'b1 : epoch;
    end
    fwd_addr  <= s1_idx;
    fwd_entry <= s1_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      novel_cnt <= '0;
      drop_cnt  <= '0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= s1_wr;
      if (s1_valid) begin
        novel_cnt <= s1_last ? '0 : novel_new;
        drop_cnt  <= s1_last ? drop_new : drop_base;
      end
    end
  end

  always_comb begin
    stored     = (fwd_valid && fwd_addr == s1_idx) ? fwd_entry : rd_entry;
    old_byte   = (stored.tag == s1_epoch) ? stored.data : '0;
    merged     = old_byte | s1_byte;
    changed    = s1_in_range && (merged != old_byte);
    s1_wr      = s1_valid && changed;
    s1_wdata   = '{tag: s1_epoch, data: merged};

    novel_base = s1_new_pass ? '0 : novel_cnt;
    novel_new  = (changed && novel_base != NOVEL_MAX) ? novel_base + 1'b1 : novel_base;
    drop_base  = s1_new_pass ? '0 : drop_cnt;
    keep       = (novel_new != '0);
    drop_new   = (!keep && drop_base != DROP_MAX) ? drop_base + 1'b1 : drop_base;

    push       = s1_valid && s1_last;
    push_data  = '{keep_case: keep, novel_bytes: novel_new, dropped_cases: drop_new};
  end

endmodule

[design/coverage_map_novelty_merge_top.sv]
// Coverage map novelty merge.
// in_ch carries one coverage byte per item: map_index, coverage_byte,
// last_byte, new_pass. Each byte is ORed into the accumulated map; a byte
// that changes the stored value counts as novel. An item with last_byte set
// yields one result on out_ch: keep_case, novel_bytes, dropped_cases.
// Items with an index at or beyond MAP_BYTES leave the map untouched.
// Throughput is one item per cycle while in_ch.ready is high: each byte
// takes one read and at most one write of the single-port-write map memory,
// with forwarding between back-to-back bytes to the same entry.
// A result is computed in the stage after its last byte is accepted, then
// waits in a three-entry result queue that feeds out_ch; when the
// receiver stalls and the queue fills, in_ch.ready drops.
// Reset: the map memory is swept to zero, entry by entry, with in_ch.ready
// low. A new pass bumps an 8-bit epoch tag instead of clearing; a new_pass
// item arriving when the epoch is at its maximum waits for another sweep
// (once per 255 passes).
module coverage_map_novelty_merge_top #(
  parameter int MAP_BYTES = cmnm_pkg::MAP_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  cmnm_in_if.sink    in_ch,
  cmnm_out_if.source out_ch
);
  import cmnm_pkg::*;

  logic             push;
  result_t          push_data;
  logic [CNT_W-1:0] fifo_count;

  cmnm_merge #(
    .MAP_BYTES (MAP_BYTES)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  cmnm_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_count),
    .out_ch    (out_ch)
  );

endmodule
